// File: sv/cdq_pkg.sv
// cdq_pkg: types and codes shared by the circular deque modules.
// No dependencies.
package cdq_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned SlotWidth  = 4;
   localparam int unsigned FillWidth  = 5;
   localparam int unsigned PeekWidth  = 4;

   typedef enum logic [2:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_BACK   = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_PEEK       = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_OUT_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]                   cmd;
      logic signed [ValueWidth-1:0] push_value;
      logic [PeekWidth-1:0]         peek_index;
   } req_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic signed [ValueWidth-1:0] read_value;
      logic [SlotWidth-1:0]         slot;
      logic [FillWidth-1:0]         fill_count;
      logic                         is_empty;
      logic                         is_full;
   } rsp_type;

   // per-transaction result info, minus the data that comes back from the RAM
   typedef struct packed {
      status_type           status;
      logic                 is_read;
      logic [SlotWidth-1:0] slot;
      logic [FillWidth-1:0] fill_count;
      logic                 is_empty;
      logic                 is_full;
   } info_type;

endpackage

// File: sv/circular_deque.sv
// circular_deque: top level of the ring-buffer deque; ties control, slot RAM
// and the result register together. Depends on cdq_pkg, cdq_ctrl, cdq_ram.
//
//   channel  ports                      direction  payload
//   req      req_valid/req_stall/req_data  in      cdq_pkg::req_type
//   rsp      rsp_valid/rsp_stall/rsp_data  out     cdq_pkg::rsp_type
//
// One transaction per cycle while no result is held by rsp_stall; each result
// appears in the cycle after its acceptance, read data from the slot RAM's registered read port.
// Reset empties the deque at once; slot contents are not cleared.
// While a result is held by rsp_stall, req_stall is raised and nothing is accepted.
module circular_deque #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cdq_pkg::rsp_type rsp_data
);
   import cdq_pkg::*;

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic                         accept;
   logic                         mem_wr_en, mem_rd_en;
   logic [AW-1:0]                mem_addr;
   logic signed [ValueWidth-1:0] mem_wr_data, mem_rd_data;
   info_type                     info;
   info_type                     info_ff;
   logic                         rsp_valid_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   cdq_ctrl #(
      .CAPACITY(CAPACITY),
      .AW      (AW),
      .CW      (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .mem_wr_en  (mem_wr_en),
      .mem_rd_en  (mem_rd_en),
      .mem_addr   (mem_addr),
      .mem_wr_data(mem_wr_data),
      .info       (info)
   );

   cdq_ram #(
      .DEPTH(CAPACITY),
      .AW   (AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .rd_en  (mem_rd_en),
      .addr   (mem_addr),
      .wr_data(mem_wr_data),
      .rd_data(mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff <= info;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.status     = info_ff.status;
   assign rsp_data.read_value = info_ff.is_read ? mem_rd_data : '0;
   assign rsp_data.slot       = info_ff.slot;
   assign rsp_data.fill_count = info_ff.fill_count;
   assign rsp_data.is_empty   = info_ff.is_empty;
   assign rsp_data.is_full    = info_ff.is_full;

endmodule

// File: sv/cdq_ram.sv
// cdq_ram: single-port slot storage, one access per cycle, registered read.
// Depends on cdq_pkg.
module cdq_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic                                 rd_en,
   input  logic [AW-1:0]                        addr,
   input  logic signed [cdq_pkg::ValueWidth-1:0] wr_data,
   output logic signed [cdq_pkg::ValueWidth-1:0] rd_data
);
   import cdq_pkg::*;

   logic signed [ValueWidth-1:0] mem [DEPTH];
   logic signed [ValueWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/cdq_ctrl.sv
// cdq_ctrl: command decode, head/tail pointers and element count.
// Issues at most one RAM access per accepted transaction. Depends on cdq_pkg.
module cdq_ctrl #(
   parameter int unsigned CAPACITY = 16,
   parameter int unsigned AW       = 4,
   parameter int unsigned CW       = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  cdq_pkg::req_type                     req,
   output logic                                 mem_wr_en,
   output logic                                 mem_rd_en,
   output logic [AW-1:0]                        mem_addr,
   output logic signed [cdq_pkg::ValueWidth-1:0] mem_wr_data,
   output cdq_pkg::info_type                    info
);
   import cdq_pkg::*;

   localparam int unsigned IW = ((AW > PeekWidth) ? AW : PeekWidth) + 1;
   localparam logic [AW-1:0] LastSlot = AW'(CAPACITY - 1);
   localparam logic [CW-1:0] FullCount = CW'(CAPACITY);
   localparam logic [IW-1:0] CapWide = IW'(CAPACITY);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic [IW-1:0] peek_sum, peek_wrap;
   logic [AW-1:0] peek_slot;
   logic          full, empty, peek_bad;
   logic [AW-1:0] addr;
   logic          wr, rd;
   status_type    status;

   assign head_inc = (head_ff == LastSlot) ? '0 : head_ff + AW'(1);
   assign head_dec = (head_ff == '0) ? LastSlot : head_ff - AW'(1);
   assign tail_inc = (tail_ff == LastSlot) ? '0 : tail_ff + AW'(1);
   assign tail_dec = (tail_ff == '0) ? LastSlot : tail_ff - AW'(1);

   assign full  = (count_ff == FullCount);
   assign empty = (count_ff == '0);

   // valid peek index is below count <= CAPACITY, so one subtract wraps it
   assign peek_sum  = IW'(head_ff) + IW'(req.peek_index);
   assign peek_wrap = (peek_sum >= CapWide) ? peek_sum - CapWide : peek_sum;
   assign peek_slot = AW'(peek_wrap);
   assign peek_bad  = (IW'(req.peek_index) >= IW'(count_ff));

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      addr     = '0;
      wr       = 1'b0;
      rd       = 1'b0;
      status   = ST_OK;
      unique case (req.cmd)
         CMD_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               addr     = tail_ff;
               wr       = 1'b1;
               tail_in  = tail_inc;
               count_in = count_ff + CW'(1);
            end
         end
         CMD_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               addr     = head_dec;
               wr       = 1'b1;
               head_in  = head_dec;
               count_in = count_ff + CW'(1);
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               addr     = tail_dec;
               rd       = 1'b1;
               tail_in  = tail_dec;
               count_in = count_ff - CW'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               addr     = head_ff;
               rd       = 1'b1;
               head_in  = head_inc;
               count_in = count_ff - CW'(1);
            end
         end
         CMD_PEEK: begin
            if (peek_bad) begin
               status = ST_OUT_RANGE;
            end else begin
               addr = peek_slot;
               rd   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign mem_wr_en   = accept & wr;
   assign mem_rd_en   = accept & rd;
   assign mem_addr    = addr;
   assign mem_wr_data = req.push_value;

   assign info.status     = status;
   assign info.is_read    = rd;
   assign info.slot       = (wr | rd) ? SlotWidth'(addr) : '0;
   assign info.fill_count = FillWidth'(count_in);
   assign info.is_empty   = (count_in == '0);
   assign info.is_full    = (count_in == FullCount);

endmodule
